### design/contact_impulse_resolver_defines.svh
// Assertion macros used by the design file contact_impulse_resolver.sv.
`ifndef CONTACT_IMPULSE_RESOLVER_DEFINES_SVH
`define CONTACT_IMPULSE_RESOLVER_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked property with reset masking.
`define CIR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("contact_impulse_resolver check failed");
// Checked property that also holds during reset.
`define CIR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
    else $error("contact_impulse_resolver check failed");
`else
`define CIR_ASSERT(lbl, clk, rst_n, prop)
`define CIR_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### design/cir_pkg.sv
`timescale 1ns / 1ps

package cir_pkg;

    typedef struct packed {
        logic signed [31:0] ref_vel_x;
        logic signed [31:0] ref_vel_y;
        logic signed [31:0] oth_vel_x;
        logic signed [31:0] oth_vel_y;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic        [15:0] ref_hardness;
        logic        [15:0] ref_elasticity;
        logic        [15:0] oth_hardness;
        logic        [15:0] oth_elasticity;
        logic        [31:0] ref_inv_mass;
        logic        [31:0] oth_inv_mass;
    } t_in;

    typedef struct packed {
        logic signed [31:0] new_ref_vel_x;
        logic signed [31:0] new_ref_vel_y;
        logic signed [31:0] new_oth_vel_x;
        logic signed [31:0] new_oth_vel_y;
        logic               impulse_applied;
    } t_out;

    // Pipeline stage numbers.
    localparam int ST_IN    = 0;
    localparam int ST_REL   = 1;
    localparam int ST_DOT   = 2;
    localparam int ST_SEP   = 3;
    localparam int ST_PROD  = 4;
    localparam int ST_DELTA = 5;
    localparam int DIV_BITS = 21;
    localparam int ST_DIV0  = 2;
    localparam int ST_DIVN  = ST_DIV0 + DIV_BITS - 1;
    localparam int ST_PP    = ST_DIVN + 1;
    localparam int ST_SH    = ST_PP + 1;
    localparam int ST_CHG   = ST_SH + 1;
    localparam int ST_OUT   = ST_CHG + 1;

    localparam logic [20:0] W_ONE = 21'h100000;

    // Shift right by 14 with rounding to nearest, ties away from zero.
    function automatic logic signed [42:0] round14(input logic signed [56:0] x);
        logic signed [56:0] t;
        t = x + (x[56] ? 57'sd8191 : 57'sd8192);
        return t[56:14];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [57:0] x);
        logic signed [31:0] y;
        if (x > 58'sd2147483647) begin
            y = 32'sh7fffffff;
        end else if (x < -58'sd2147483648) begin
            y = 32'sh80000000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

endpackage

### design/contact_impulse_resolver.sv
// Throughput: one item per cycle while the output is not stalled; the division runs as a
// 21-stage restoring divider, which resolves one quotient bit per stage and so takes a new item every cycle.
// Reset (i_rst_n low at a clock edge) empties the pipeline: all valid bits clear.
// No state survives between items, so the block is ready once reset has cleared the valid bits.
`timescale 1ns / 1ps

`include "contact_impulse_resolver_defines.svh"

module contact_impulse_resolver (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cir_pkg::t_in    i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output cir_pkg::t_out   o_data
);

    // The whole pipeline advances together. It moves whenever the output
    // register is empty or being drained, so a stall simply freezes every
    // stage and nothing is dropped or repeated.
    logic en;

    logic         r_valid [cir_pkg::ST_IN:cir_pkg::ST_OUT];
    cir_pkg::t_in r_item  [cir_pkg::ST_IN:cir_pkg::ST_CHG];

    // Stage 1: relative velocity, total inverse mass, restitution sum.
    logic signed [32:0] r_rel_x, r_rel_y;
    logic        [32:0] r_rhe;
    logic        [32:0] r_tot [cir_pkg::ST_REL:cir_pkg::ST_DIVN];

    // Stage 2: normal products and the 1+r factor.
    logic signed [48:0] r_px, r_py;
    logic        [19:0] r_f2, r_f3;

    // Stage 3 onward: approach flag, rounded speed, delta.
    logic               r_app   [cir_pkg::ST_SEP:cir_pkg::ST_CHG];
    logic        [35:0] r_s;
    logic        [55:0] r_prod;
    logic        [39:0] r_delta [cir_pkg::ST_DELTA:cir_pkg::ST_DIVN];

    // Divider: one quotient bit per stage, weight of the reference body.
    logic        [20:0] r_quo [0:cir_pkg::DIV_BITS-1];
    logic        [32:0] r_rem [0:cir_pkg::DIV_BITS-1];

    // Share and velocity change stages.
    logic        [40:0] r_pp_lo_ref, r_pp_hi_ref, r_pp_lo_oth, r_pp_hi_oth;
    logic        [39:0] r_sh_ref, r_sh_oth;
    logic signed [56:0] r_cx_ref, r_cy_ref, r_cx_oth, r_cy_oth;
    cir_pkg::t_out      r_out;

    // Combinational helpers for the stages.
    logic signed [49:0] n_sep;
    logic        [49:0] n_mag;
    logic        [33:0] n_fsum;
    logic        [20:0] n_w_ref, n_w_oth;
    logic        [61:0] n_sum_ref, n_sum_oth;
    logic        [33:0] n_div_t   [0:cir_pkg::DIV_BITS-1];
    logic               n_div_q   [0:cir_pkg::DIV_BITS-1];
    logic        [32:0] n_div_tot [0:cir_pkg::DIV_BITS-1];
    cir_pkg::t_out      n_out;

    assign en      = !r_valid[cir_pkg::ST_OUT] || i_ready;
    assign o_ready = en;
    assign o_valid = r_valid[cir_pkg::ST_OUT];
    assign o_data  = r_out;

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = cir_pkg::ST_IN; k <= cir_pkg::ST_OUT; k++) begin
                r_valid[k] <= 1'b0;
            end
        end else if (en) begin
            r_valid[cir_pkg::ST_IN] <= i_valid;
            for (int k = cir_pkg::ST_IN + 1; k <= cir_pkg::ST_OUT; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    // Restoring division of ref_inv_mass * 2^20 by the total inverse mass.
    // The first step compares the inverse mass itself (the top quotient bit);
    // each later step doubles the remainder, since the dividend's low bits are
    // all zero.
    always_comb begin
        for (int j = 0; j < cir_pkg::DIV_BITS; j++) begin
            n_div_tot[j] = r_tot[cir_pkg::ST_DIV0 + j - 1];
            if (j == 0) begin
                n_div_t[j] = {2'b00, r_item[cir_pkg::ST_REL].ref_inv_mass};
            end else begin
                n_div_t[j] = {r_rem[j-1], 1'b0};
            end
            n_div_q[j] = n_div_t[j] >= {1'b0, n_div_tot[j]};
        end
    end

    always_comb begin
        n_sep   = 50'(r_px) + 50'(r_py);
        n_mag   = 50'(0) - n_sep;
        n_fsum  = 34'h40000000 + {1'b0, r_rhe} + 34'd8192;
        // Truncated weights of the two bodies add to 2^20, less one when the
        // division leaves a remainder.
        n_w_ref = r_quo[cir_pkg::DIV_BITS-1];
        n_w_oth = cir_pkg::W_ONE - n_w_ref
                  - 21'(r_rem[cir_pkg::DIV_BITS-1] != 33'd0);
        n_sum_ref = {r_pp_hi_ref, 21'd0} >> 1;
        n_sum_ref = n_sum_ref + 62'(r_pp_lo_ref) + 62'd524288;
        n_sum_oth = {r_pp_hi_oth, 21'd0} >> 1;
        n_sum_oth = n_sum_oth + 62'(r_pp_lo_oth) + 62'd524288;
    end

    // Final stage: apply the rounded normal changes and saturate. Items with
    // no impulse pass their velocities through untouched.
    always_comb begin
        cir_pkg::t_in it;
        it = r_item[cir_pkg::ST_CHG];
        n_out.impulse_applied = r_app[cir_pkg::ST_CHG];
        if (r_app[cir_pkg::ST_CHG]) begin
            n_out.new_ref_vel_x = cir_pkg::sat32(58'(it.ref_vel_x)
                                  + 58'(cir_pkg::round14(r_cx_ref)));
            n_out.new_ref_vel_y = cir_pkg::sat32(58'(it.ref_vel_y)
                                  + 58'(cir_pkg::round14(r_cy_ref)));
            n_out.new_oth_vel_x = cir_pkg::sat32(58'(it.oth_vel_x)
                                  - 58'(cir_pkg::round14(r_cx_oth)));
            n_out.new_oth_vel_y = cir_pkg::sat32(58'(it.oth_vel_y)
                                  - 58'(cir_pkg::round14(r_cy_oth)));
        end else begin
            n_out.new_ref_vel_x = it.ref_vel_x;
            n_out.new_ref_vel_y = it.ref_vel_y;
            n_out.new_oth_vel_x = it.oth_vel_x;
            n_out.new_oth_vel_y = it.oth_vel_y;
        end
    end

    // Datapath registers. Carried values shift one stage per enable; the
    // stage that produces a value overrides the shifted copy below.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_item[cir_pkg::ST_IN] <= i_data;
            for (int k = cir_pkg::ST_IN + 1; k <= cir_pkg::ST_CHG; k++) begin
                r_item[k] <= r_item[k-1];
            end
            for (int k = cir_pkg::ST_REL + 1; k <= cir_pkg::ST_DIVN; k++) begin
                r_tot[k] <= r_tot[k-1];
            end
            for (int k = cir_pkg::ST_SEP + 1; k <= cir_pkg::ST_CHG; k++) begin
                r_app[k] <= r_app[k-1];
            end
            for (int k = cir_pkg::ST_DELTA + 1; k <= cir_pkg::ST_DIVN; k++) begin
                r_delta[k] <= r_delta[k-1];
            end

            // Stage 1: differences, total mass, restitution products.
            r_rel_x <= 33'(r_item[cir_pkg::ST_IN].ref_vel_x)
                       - 33'(r_item[cir_pkg::ST_IN].oth_vel_x);
            r_rel_y <= 33'(r_item[cir_pkg::ST_IN].ref_vel_y)
                       - 33'(r_item[cir_pkg::ST_IN].oth_vel_y);
            r_tot[cir_pkg::ST_REL] <= 33'(r_item[cir_pkg::ST_IN].ref_inv_mass)
                                      + 33'(r_item[cir_pkg::ST_IN].oth_inv_mass);
            r_rhe <= 33'({16'd0, r_item[cir_pkg::ST_IN].ref_hardness}
                         * r_item[cir_pkg::ST_IN].oth_elasticity)
                   + 33'({16'd0, r_item[cir_pkg::ST_IN].ref_elasticity}
                         * r_item[cir_pkg::ST_IN].oth_hardness);

            // Stage 2: normal products and 1+r rounded to Q.16.
            r_px <= r_rel_x * r_item[cir_pkg::ST_REL].normal_x;
            r_py <= r_rel_y * r_item[cir_pkg::ST_REL].normal_y;
            r_f2 <= n_fsum[33:14];

            // Stage 3: separating velocity sign and rounded magnitude.
            r_app[cir_pkg::ST_SEP] <= n_sep[49]
                                      && (r_tot[cir_pkg::ST_DOT] != 33'd0);
            r_s  <= 36'((n_mag + 50'd8192) >> 14);
            r_f3 <= r_f2;

            // Stages 4 and 5: speed times factor, then rounding.
            r_prod <= r_s * r_f3;
            r_delta[cir_pkg::ST_DELTA] <= 40'((r_prod + 56'd32768) >> 16);

            // Divider stages.
            for (int j = 0; j < cir_pkg::DIV_BITS; j++) begin
                r_rem[j] <= n_div_q[j] ? 33'(n_div_t[j] - {1'b0, n_div_tot[j]})
                                       : n_div_t[j][32:0];
                if (j == 0) begin
                    r_quo[j] <= 21'(n_div_q[j]);
                end else begin
                    r_quo[j] <= {r_quo[j-1][19:0], n_div_q[j]};
                end
            end

            // Delta times weight, split into two narrow partial products.
            r_pp_lo_ref <= r_delta[cir_pkg::ST_DIVN][19:0]  * n_w_ref;
            r_pp_hi_ref <= r_delta[cir_pkg::ST_DIVN][39:20] * n_w_ref;
            r_pp_lo_oth <= r_delta[cir_pkg::ST_DIVN][19:0]  * n_w_oth;
            r_pp_hi_oth <= r_delta[cir_pkg::ST_DIVN][39:20] * n_w_oth;

            // Each body's share of delta, rounded by 20 bits.
            r_sh_ref <= n_sum_ref[59:20];
            r_sh_oth <= n_sum_oth[59:20];

            // Shares projected onto the normal.
            r_cx_ref <= r_item[cir_pkg::ST_SH].normal_x * $signed({1'b0, r_sh_ref});
            r_cy_ref <= r_item[cir_pkg::ST_SH].normal_y * $signed({1'b0, r_sh_ref});
            r_cx_oth <= r_item[cir_pkg::ST_SH].normal_x * $signed({1'b0, r_sh_oth});
            r_cy_oth <= r_item[cir_pkg::ST_SH].normal_y * $signed({1'b0, r_sh_oth});

            r_out <= n_out;
        end
    end

    // An item without impulse leaves with its input reference x velocity.
    `CIR_ASSERT(a_pass_through, i_clk, i_rst_n, (en && r_valid[cir_pkg::ST_CHG] && !r_app[cir_pkg::ST_CHG]) |=> (r_out.new_ref_vel_x == $past(r_item[cir_pkg::ST_CHG].ref_vel_x)))
    // The weight never exceeds one when the total is nonzero.
    `CIR_ASSERT(a_weight_range, i_clk, i_rst_n, (r_valid[cir_pkg::ST_DIVN] && r_tot[cir_pkg::ST_DIVN] != 33'd0) |-> (r_quo[cir_pkg::DIV_BITS-1] <= cir_pkg::W_ONE))
    // The final remainder stays below the divisor.
    `CIR_ASSERT(a_rem_range, i_clk, i_rst_n, (r_valid[cir_pkg::ST_DIVN] && r_tot[cir_pkg::ST_DIVN] != 33'd0) |-> (r_rem[cir_pkg::DIV_BITS-1] < r_tot[cir_pkg::ST_DIVN]))

endmodule

### sim/contact_impulse_resolver_tb.sv
`timescale 1ns / 1ps

module contact_impulse_resolver_tb;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    cir_pkg::t_in i_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    cir_pkg::t_out o_data;

    contact_impulse_resolver dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always #4 i_clk = ~i_clk;

    localparam int DIRECTED = 16;
    localparam int RANDOM_ITEMS = 1300;

    cir_pkg::t_out expected_results[$];
    int errors = 0;
    bit sending_done = 1'b0;

    task automatic report(input string what, input cir_pkg::t_out got,
                          input cir_pkg::t_out want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        errors++;
    endtask

    // Round a signed value right by k, ties away from zero.
    function automatic longint round_shift(input longint x, input int k);
        longint half;
        half = longint'(1) << (k - 1);
        if (x < 0) return -((-x + half) >>> k);
        return (x + half) >>> k;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    // Impulse resolution of one contact.
    function automatic cir_pkg::t_out resolve_contact(input cir_pkg::t_in c);
        cir_pkg::t_out r;
        longint rvx, rvy, ovx, ovy, nx, ny, sep, sh_ref, sh_oth;
        longint unsigned total, mag, s, rest, f, delta, w_ref, w_oth;
        rvx = c.ref_vel_x; rvy = c.ref_vel_y;
        ovx = c.oth_vel_x; ovy = c.oth_vel_y;
        nx = c.normal_x; ny = c.normal_y;
        total = longint'(c.ref_inv_mass) + longint'(c.oth_inv_mass);
        sep = (rvx - ovx) * nx + (rvy - ovy) * ny;
        r.impulse_applied = 1'b0;
        if (sep < 0 && total != 0) begin
            mag = -sep;
            s = (mag + (64'd1 << 13)) >> 14;
            rest = longint'(c.ref_hardness) * c.oth_elasticity
                 + longint'(c.ref_elasticity) * c.oth_hardness;
            f = ((64'd1 << 30) + rest + (64'd1 << 13)) >> 14;
            delta = (s * f + (64'd1 << 15)) >> 16;
            w_ref = (longint'(c.ref_inv_mass) << 20) / total;
            w_oth = (longint'(c.oth_inv_mass) << 20) / total;
            sh_ref = (delta * w_ref + (64'd1 << 19)) >> 20;
            sh_oth = (delta * w_oth + (64'd1 << 19)) >> 20;
            rvx += round_shift(nx * sh_ref, 14);
            rvy += round_shift(ny * sh_ref, 14);
            ovx -= round_shift(nx * sh_oth, 14);
            ovy -= round_shift(ny * sh_oth, 14);
            r.impulse_applied = 1'b1;
        end
        r.new_ref_vel_x = clamp32(rvx);
        r.new_ref_vel_y = clamp32(rvy);
        r.new_oth_vel_x = clamp32(ovx);
        r.new_oth_vel_y = clamp32(ovy);
        return r;
    endfunction

    function automatic cir_pkg::t_in random_contact();
        cir_pkg::t_in c;
        c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom};
        if ($urandom_range(0, 9) < 8) begin
            // Mostly well-formed contacts: unit-ish normal, Q1.15 factors in range,
            // moderate speeds in half of them, so the impulse path is exercised.
            c.normal_x = 16'($signed($urandom_range(0, 32768)) - 16384);
            c.normal_y = 16'($signed($urandom_range(0, 32768)) - 16384);
            c.ref_hardness = 16'($urandom_range(0, 32768));
            c.ref_elasticity = 16'($urandom_range(0, 32768));
            c.oth_hardness = 16'($urandom_range(0, 32768));
            c.oth_elasticity = 16'($urandom_range(0, 32768));
            if ($urandom_range(0, 1)) begin
                c.ref_vel_x = $signed($urandom) >>> $urandom_range(0, 16);
                c.ref_vel_y = $signed($urandom) >>> $urandom_range(0, 16);
                c.oth_vel_x = $signed($urandom) >>> $urandom_range(0, 16);
                c.oth_vel_y = $signed($urandom) >>> $urandom_range(0, 16);
            end
            case ($urandom_range(0, 5))
                0: c.ref_inv_mass = '0;
                1: c.oth_inv_mass = '0;
                2: begin c.ref_inv_mass = '0; c.oth_inv_mass = '0; end
                3: begin
                    c.ref_inv_mass = c.ref_inv_mass >> $urandom_range(0, 31);
                    c.oth_inv_mass = c.oth_inv_mass >> $urandom_range(0, 31);
                end
                default: ;
            endcase
        end
        return c;
    endfunction

    // Directed table: extremes and special cases; a typed-in expectation is
    // used where has_exp is set.
    cir_pkg::t_in dir_in[DIRECTED];
    cir_pkg::t_out dir_exp[DIRECTED];
    bit dir_has_exp[DIRECTED];

    initial begin
        cir_pkg::t_in c;
        cir_pkg::t_in base;
        base = '0;
        base.normal_x = 16'sd16384;
        base.ref_hardness = 16'd32768; base.ref_elasticity = 16'd32768;
        base.oth_hardness = 16'd32768; base.oth_elasticity = 16'd32768;
        base.ref_inv_mass = 32'h10000; base.oth_inv_mass = 32'h10000;
        for (int i = 0; i < DIRECTED; i++) begin
            dir_has_exp[i] = 1'b0; dir_exp[i] = '0;
        end
        // All zero: not approaching, pass through.
        dir_in[0] = '0; dir_has_exp[0] = 1'b1;
        // Separating: velocities unchanged.
        c = base; c.ref_vel_x = 32'sh10000; c.oth_vel_x = -32'sh10000;
        dir_in[1] = c; dir_has_exp[1] = 1'b1;
        dir_exp[1] = '{32'sh10000, 32'sd0, -32'sh10000, 32'sd0, 1'b0};
        // Approaching but both bodies immovable.
        c = base; c.ref_vel_x = -32'sh10000; c.ref_inv_mass = '0; c.oth_inv_mass = '0;
        dir_in[2] = c; dir_has_exp[2] = 1'b1;
        dir_exp[2] = '{-32'sh10000, 32'sd0, 32'sd0, 32'sd0, 1'b0};
        // Head-on, equal masses, full restitution.
        c = base; c.ref_vel_x = -32'sh10000; c.oth_vel_x = 32'sh10000;
        dir_in[3] = c;
        // Tiny approach: delta rounds to zero, still applied.
        c = base; c.ref_vel_x = -32'sd0; c.normal_x = -16'sd1; c.ref_vel_x = 32'sd1;
        dir_in[4] = c;
        // Extreme velocities, saturation both ways.
        c = base; c.ref_vel_x = 32'sh80000000; c.oth_vel_x = 32'sh7fffffff;
        dir_in[5] = c;
        c = base; c.normal_x = -16'sd16384;
        c.ref_vel_x = 32'sh7fffffff; c.oth_vel_x = 32'sh80000000;
        dir_in[6] = c;
        // Out-of-range normal and factors at all ones.
        c = '1; c.ref_vel_x = 32'sh80000000; c.ref_vel_y = 32'sh80000000;
        dir_in[7] = c;
        c = base; c.normal_x = 16'sh8000; c.normal_y = 16'sh7fff;
        c.ref_vel_x = 32'sh12345; c.ref_vel_y = -32'sh54321;
        dir_in[8] = c;
        // One side immovable.
        c = base; c.ref_vel_y = -32'sh30000; c.normal_x = '0; c.normal_y = 16'sd16384;
        c.ref_inv_mass = '0; dir_in[9] = c;
        c = dir_in[9]; c.ref_inv_mass = 32'h10000; c.oth_inv_mass = '0; dir_in[10] = c;
        // Largest inverse masses.
        c = base; c.ref_vel_x = -32'sh7fff; c.ref_inv_mass = '1; c.oth_inv_mass = '1;
        dir_in[11] = c;
        c = dir_in[11]; c.oth_inv_mass = 32'd1; dir_in[12] = c;
        // Zero restitution, diagonal normal.
        c = base; c.ref_hardness = '0; c.oth_hardness = '0; c.normal_x = 16'sd11585;
        c.normal_y = 16'sd11585; c.oth_vel_x = 32'sh20000; c.oth_vel_y = 32'sh20000;
        dir_in[13] = c;
        c = '1; dir_in[14] = c;
        c = '0; c.normal_y = -16'sd16384; c.ref_vel_y = 32'sh7fffffff;
        c.oth_inv_mass = 32'h80000000; dir_in[15] = c;
        for (int i = 0; i < DIRECTED; i++)
            if (dir_has_exp[i] && i == 0) dir_exp[i] = '0;
    end

    // Sender.
    initial begin
        int gap;
        int burst;
        cir_pkg::t_in c;
        burst = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < DIRECTED + RANDOM_ITEMS; i++) begin
            if (i < DIRECTED) c = dir_in[i];
            else c = random_contact();
            gap = 0;
            if (i >= DIRECTED) begin
                if (burst == 0) begin
                    burst = $urandom_range(1, 40);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
                burst--;
            end
            if (gap > 0 || i == DIRECTED + 400) begin
                // Nothing is offered while the sender idles.
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                if (i == DIRECTED + 400) begin
                    // Pause until every result is back.
                    do @(posedge i_clk); while (expected_results.size() != 0);
                end
            end
            i_valid <= 1'b1;
            i_data <= c;
            if (i < DIRECTED && dir_has_exp[i]) expected_results.push_back(dir_exp[i]);
            else expected_results.push_back(resolve_contact(c));
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
        end
        i_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Receiver stall pattern with one long hold-off.
    initial begin
        int phase;
        phase = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            phase++;
            if (phase == 300) begin
                i_ready <= 1'b0;
                repeat (200) @(posedge i_clk);
            end
            if (phase < 150) i_ready <= 1'b1;
            else i_ready <= ((phase % 7) != 3) && ($urandom_range(0, 4) != 0);
        end
    end

    // Result checking.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                report("unexpected result", o_data, '0);
            end else begin
                cir_pkg::t_out w;
                w = expected_results.pop_front();
                if (o_data !== w)
                    report("result", o_data, w);
            end
        end
    end

    // End of run.
    initial begin
        wait (sending_done);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
